// File: sv/crpcap_pkg.sv
// ----------------------------------------------------------------------------
// crpcap_pkg: shared types and constants for the pcap record formatter
// Job and pipeline carry structs, phase and sequencer codes, fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package crpcap_pkg;

    // fixed field widths
    localparam int RAW_W        = 64;
    localparam int SYNC_CNT_W   = 46;
    localparam int SYNC_NS_W    = 63;
    localparam int BYTES_W      = 4;
    localparam int US_W         = 55;   // ns / 1000 of a 64-bit value
    localparam int HDR_TICK_LSB = 18;
    localparam int PLEN_W       = 16;

    // constant dividers
    localparam int DIV_LAT      = 5;    // number of pipeline stages in crpcap_cdiv
    localparam int TICK_DIV     = 625;  // tick*4/625 gives microseconds
    localparam int SERVO_DIV    = 5;    // tick*32/5 gives nanoseconds
    localparam int NS_PER_US    = 1000;
    localparam int US_PER_S     = 1000000;

    // queue
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    // configuration
    localparam logic       ADDR_SHIFT  = 1'b0;
    localparam logic [2:0] SHIFT_RESET = 3'd3;

    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_PAY,
        KIND_SYNC
    } t_kind;

    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_PAY = 2'd1,
        PH_PAD = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        SY_IDLE,
        SY_WAIT_DIV,
        SY_ERR,
        SY_MAG,
        SY_APPLY,
        SY_LAUNCH,
        SY_WAIT_US
    } t_sync_state;

    // classified item from the front end
    typedef struct packed {
        t_kind                  kind;
        logic [RAW_W-1:0]       data;    // raw header word or masked payload
        logic [BYTES_W-1:0]     bytes;
        logic                   last;
        logic [SYNC_CNT_W-1:0]  count;
        logic [SYNC_NS_W-1:0]   time_ns;
        logic                   init;
    } t_job;

    // request into the servo unit
    typedef struct packed {
        logic                   start;
        logic                   init;
        logic [SYNC_CNT_W-1:0]  count;
        logic [SYNC_NS_W-1:0]   time_ns;
    } t_sync_req;

    // side data riding along the timestamp pipeline
    typedef struct packed {
        logic                   vld;
        logic                   hdr;
        logic [RAW_W-1:0]       data;
        logic [BYTES_W-1:0]     bytes;
        logic                   last;
        logic [US_W-1:0]        ref_us;
    } t_carry;

endpackage

`default_nettype wire

// File: sv/crpcap_cdiv.sv
// ----------------------------------------------------------------------------
// crpcap_cdiv: pipelined unsigned division by a constant
// Reciprocal multiply in 32-bit partial products, then one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module crpcap_cdiv
    import crpcap_pkg::*;
#(
    parameter int W = 64,
    parameter int D = 1000
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic [W-1:0]         i_x,
    output logic                      o_vld,
    output logic [W-1:0]              o_q,
    output logic [$clog2(D)-1:0]      o_r
);

    localparam int         RW    = $clog2(D);
    localparam logic [W:0] ONE_W = {1'b1, {W{1'b0}}};
    localparam logic [W-1:0] RECIP = W'(ONE_W / D);
    localparam logic [W-1:0] DC    = W'(D);

    logic [63:0]  xa, ma;
    logic [127:0] full;
    logic [W-1:0] n_q, n_r;

    logic [4:0]   r_vld;
    logic [63:0]  r_pll, r_plh, r_phl, r_phh;
    logic [W-1:0] r_x1, r_x2, r_x3;
    logic [63:0]  r_ll, r_hh;
    logic [64:0]  r_mid;
    logic [W-1:0] r_q3, r_q4, r_r4;
    logic [W-1:0] r_q;
    logic [RW-1:0] r_r;

    assign xa = 64'(i_x);
    assign ma = 64'(RECIP);

    // sum of partial products, quotient estimate from the top half
    assign full = 128'(r_ll) + (128'(r_mid) << 32) + (128'(r_hh) << 64);

    // estimate is low by at most one
    always_comb begin
        if (r_r4 >= DC) begin
            n_q = r_q4 + W'(1);
            n_r = r_r4 - DC;
        end else begin
            n_q = r_q4;
            n_r = r_r4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products
            r_pll <= xa[31:0]  * ma[31:0];
            r_plh <= xa[31:0]  * ma[63:32];
            r_phl <= xa[63:32] * ma[31:0];
            r_phh <= xa[63:32] * ma[63:32];
            r_x1  <= i_x;
            // middle terms
            r_ll  <= r_pll;
            r_hh  <= r_phh;
            r_mid <= {1'b0, r_plh} + {1'b0, r_phl};
            r_x2  <= r_x1;
            // quotient estimate
            r_q3  <= full[W +: W];
            r_x3  <= r_x2;
            // remainder of the estimate
            r_q4  <= r_q3;
            r_r4  <= r_x3 - W'(r_q3 * DC);
            // corrected result
            r_q   <= n_q;
            r_r   <= RW'(n_r);
        end
    end

    assign o_vld = r_vld[4];
    assign o_q   = r_q;
    assign o_r   = r_r;

endmodule

`default_nettype wire

// File: sv/crpcap_queue.sv
// ----------------------------------------------------------------------------
// crpcap_queue: short job queue between front and back end
// Four entries, simultaneous push and pop, head readable combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module crpcap_queue
    import crpcap_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= r_rd + Q_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

`default_nettype wire

// File: sv/crpcap_front.sv
// ----------------------------------------------------------------------------
// crpcap_front: record parser
// Tracks header / payload / padding phase, masks the tail payload word,
// drops padding and queues header, payload and sync jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module crpcap_front
    import crpcap_pkg::*;
#(
    parameter int ALIGN_LOG2 = 4
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    input  wire logic                                    i_kind,
    input  wire logic [RAW_W+SYNC_CNT_W+SYNC_NS_W+1-1:0] i_fields,
    output logic                                         o_ready,
    input  wire logic                                    i_full,
    output logic                                         o_push,
    output t_job                                         o_job
);

    localparam int PAD_W = (ALIGN_LOG2 > 3) ? ALIGN_LOG2 - 3 : 1;
    localparam int SUM_W = PLEN_W + 2;

    t_phase           r_phase, n_phase;
    logic [PLEN_W-1:0] r_left, n_left;
    logic [PAD_W-1:0]  r_pad, n_pad;

    logic              acc;
    logic [RAW_W-1:0]  raw;
    logic [3:0]        nb;
    logic [RAW_W-1:0]  masked;
    logic [PLEN_W-1:0] plen, left_after;
    logic [SUM_W-1:0]  sum, words, pwords, pad_full;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign raw     = i_fields[RAW_W-1:0];
    assign plen    = raw[PLEN_W-1:0];

    // byte count of this payload word and its tail mask
    always_comb begin
        nb = (r_left >= PLEN_W'(8)) ? 4'd8 : r_left[3:0];
        for (int b = 0; b < 8; b++) begin
            masked[8*b +: 8] = (4'(b) < nb) ? raw[8*b +: 8] : 8'h00;
        end
        left_after = r_left - PLEN_W'(nb);
    end

    // record size rounded up to the alignment, counting the header
    always_comb begin
        sum      = SUM_W'(plen) + SUM_W'(1 << ALIGN_LOG2) + SUM_W'(7);
        words    = (sum >> ALIGN_LOG2) << (ALIGN_LOG2 - 3);
        pwords   = (SUM_W'(plen) + SUM_W'(7)) >> 3;
        pad_full = words - SUM_W'(1) - pwords;
    end

    // phase tracking and job formation
    always_comb begin
        n_phase      = r_phase;
        n_left       = r_left;
        n_pad        = r_pad;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.count  = i_fields[RAW_W +: SYNC_CNT_W];
        o_job.time_ns = i_fields[RAW_W+SYNC_CNT_W +: SYNC_NS_W];
        o_job.init   = i_fields[RAW_W+SYNC_CNT_W+SYNC_NS_W];
        if (acc) begin
            if (i_kind) begin
                o_push     = 1'b1;
                o_job.kind = KIND_SYNC;
            end else begin
                case (r_phase)
                    PH_PAY: begin
                        o_push      = 1'b1;
                        o_job.kind  = KIND_PAY;
                        o_job.data  = masked;
                        o_job.bytes = nb;
                        o_job.last  = (left_after == '0);
                        n_left      = left_after;
                        if (left_after == '0) begin
                            n_phase = (r_pad != '0) ? PH_PAD : PH_HDR;
                        end
                    end
                    PH_PAD: begin
                        // padding word is dropped
                        if (r_pad != '0) n_pad = r_pad - PAD_W'(1);
                        if (r_pad <= PAD_W'(1)) n_phase = PH_HDR;
                    end
                    default: begin
                        o_push      = 1'b1;
                        o_job.kind  = KIND_HDR;
                        o_job.data  = raw;
                        o_job.bytes = 4'd8;
                        o_job.last  = (plen == '0);
                        n_left      = plen;
                        n_pad       = PAD_W'(pad_full);
                        if (plen != '0) begin
                            n_phase = PH_PAY;
                        end else begin
                            n_phase = (PAD_W'(pad_full) != '0) ? PH_PAD : PH_HDR;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_left  <= '0;
            r_pad   <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pad   <= n_pad;
        end
    end

endmodule

`default_nettype wire

// File: sv/crpcap_sync.sv
// ----------------------------------------------------------------------------
// crpcap_sync: clock reference servo
// Holds the reference tick count and time, applies sync samples and keeps
// the reference in microseconds for the timestamp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module crpcap_sync
    import crpcap_pkg::*;
#(
    parameter int TICK_BITS = 46
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_sync_req            i_req,
    input  wire logic [2:0]           i_shift,
    output logic                      o_busy,
    output logic [TICK_BITS-1:0]      o_ref_tick,
    output logic [US_W-1:0]           o_ref_us
);

    localparam int DW = TICK_BITS + 5;

    t_sync_state r_state, n_state;

    logic [TICK_BITS-1:0] r_ref_tick, r_count, req_count;
    logic [63:0]          r_ref_ns, r_est, r_err, r_mag;
    logic                 r_neg;
    logic [SYNC_NS_W-1:0] r_time;
    logic [US_W-1:0]      r_ref_us;

    logic                 div5_go, div5_vld, div_us_go, div_us_vld;
    logic [DW-1:0]        div5_x, div5_q;
    logic [63:0]          div_us_q;

    assign req_count = TICK_BITS'(i_req.count);
    assign div5_x    = {req_count - r_ref_tick, 5'b00000};

    // tick difference to nanoseconds
    crpcap_cdiv #(.W(DW), .D(SERVO_DIV)) u_div5 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_vld   (div5_go),
        .i_x     (div5_x),
        .o_vld   (div5_vld),
        .o_q     (div5_q),
        .o_r     ()
    );

    // reference nanoseconds to microseconds
    crpcap_cdiv #(.W(64), .D(NS_PER_US)) u_div_us (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_vld   (div_us_go),
        .i_x     (r_ref_ns),
        .o_vld   (div_us_vld),
        .o_q     (div_us_q),
        .o_r     ()
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SY_IDLE: begin
                if (i_req.start) n_state = i_req.init ? SY_LAUNCH : SY_WAIT_DIV;
            end
            SY_WAIT_DIV: begin
                if (div5_vld) n_state = SY_ERR;
            end
            SY_ERR:    n_state = SY_MAG;
            SY_MAG:    n_state = SY_APPLY;
            SY_APPLY:  n_state = SY_LAUNCH;
            SY_LAUNCH: n_state = SY_WAIT_US;
            SY_WAIT_US: begin
                if (div_us_vld) n_state = SY_IDLE;
            end
            default:   n_state = SY_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy    = (r_state != SY_IDLE);
        div5_go   = (r_state == SY_IDLE) && i_req.start && !i_req.init;
        div_us_go = (r_state == SY_LAUNCH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SY_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // reference update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_tick <= '0;
            r_ref_ns   <= '0;
            r_ref_us   <= '0;
        end else begin
            case (r_state)
                SY_IDLE: begin
                    if (i_req.start && i_req.init) begin
                        r_ref_tick <= req_count;
                        r_ref_ns   <= 64'(i_req.time_ns);
                    end
                end
                SY_APPLY: begin
                    r_ref_tick <= r_count;
                    r_ref_ns   <= r_neg ? (r_est - r_mag) : (r_est + r_mag);
                end
                SY_WAIT_US: begin
                    if (div_us_vld) r_ref_us <= div_us_q[US_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // servo arithmetic
    always_ff @(posedge i_clk) begin
        if (r_state == SY_IDLE && i_req.start) begin
            r_count <= req_count;
            r_time  <= i_req.time_ns;
        end
        if (r_state == SY_WAIT_DIV && div5_vld) begin
            r_est <= r_ref_ns + 64'(div5_q);
        end
        if (r_state == SY_ERR) begin
            r_err <= 64'(r_time) - r_est;
        end
        if (r_state == SY_MAG) begin
            // error magnitude shifted, sign kept apart: rounds toward zero
            r_neg <= r_err[63];
            r_mag <= (r_err[63] ? (~r_err + 64'd1) : r_err) >> i_shift;
        end
    end

    assign o_ref_tick = r_ref_tick;
    assign o_ref_us   = r_ref_us;

endmodule

`default_nettype wire

// File: sv/crpcap_back.sv
// ----------------------------------------------------------------------------
// crpcap_back: timestamp pipeline and output formatter
// Issues queued jobs, dates headers (tick diff to us, then sec/usec split),
// and emits the two pcap header beats followed by payload beats.
// ----------------------------------------------------------------------------
`default_nettype none

module crpcap_back
    import crpcap_pkg::*;
#(
    parameter int TICK_BITS = 46
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_qvalid,
    input  wire t_job                 i_job,
    output logic                      o_pop,
    output t_sync_req                 o_sync_req,
    input  wire logic                 i_sync_busy,
    input  wire logic [TICK_BITS-1:0] i_ref_tick,
    input  wire logic [US_W-1:0]      i_ref_us,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [RAW_W-1:0]          o_data,
    output logic [BYTES_W-1:0]        o_bytes,
    output logic                      o_first,
    output logic                      o_last
);

    localparam int XW = TICK_BITS + 2;
    localparam int RW = $clog2(US_PER_S);

    logic                 en, issue;
    logic [TICK_BITS-1:0] tick, tickdiff;

    t_carry               r_s1, r_s7, src;
    t_carry               r_ca [DIV_LAT];
    t_carry               r_cb [DIV_LAT];
    logic [XW-1:0]        r_x;
    logic [XW-1:0]        q_us;
    logic [US_W-1:0]      q_us_ext, r_ts;
    logic [US_W-1:0]      q_sec;
    logic [RW-1:0]        r_usec;

    logic                 r_out_vld, r_out_first, r_out_last;
    logic [RAW_W-1:0]     r_out_data;
    logic [BYTES_W-1:0]   r_out_bytes;
    logic                 r_pend, r_pend_last;
    logic [PLEN_W-1:0]    r_pend_len;

    // whole pipeline advances when the output slot can take a beat
    assign en    = !r_out_vld || (i_ready && !r_pend);
    assign issue = i_qvalid && en && !i_sync_busy;
    assign o_pop = issue;

    assign tick     = TICK_BITS'(i_job.data[RAW_W-1:HDR_TICK_LSB]);
    assign tickdiff = i_ref_tick - tick;

    // sync jobs go to the servo; issue then waits for it
    always_comb begin
        o_sync_req.start   = issue && (i_job.kind == KIND_SYNC);
        o_sync_req.init    = i_job.init;
        o_sync_req.count   = i_job.count;
        o_sync_req.time_ns = i_job.time_ns;
    end

    // issue stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en) begin
            r_s1.vld    <= issue && (i_job.kind != KIND_SYNC);
            r_s1.hdr    <= (i_job.kind == KIND_HDR);
            r_s1.data   <= i_job.data;
            r_s1.bytes  <= i_job.bytes;
            r_s1.last   <= i_job.last;
            r_s1.ref_us <= i_ref_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_x <= {tickdiff, 2'b00};
    end

    // tick difference in microseconds
    crpcap_cdiv #(.W(XW), .D(TICK_DIV)) u_div_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s1.vld),
        .i_x     (r_x),
        .o_vld   (),
        .o_q     (q_us),
        .o_r     ()
    );

    // carry lines alongside both dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_ca[i] <= '0;
                r_cb[i] <= '0;
            end
            r_s7 <= '0;
        end else if (en) begin
            r_ca[0] <= r_s1;
            r_cb[0] <= r_s7;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_ca[i] <= r_ca[i-1];
                r_cb[i] <= r_cb[i-1];
            end
            r_s7 <= r_ca[DIV_LAT-1];
        end
    end

    // timestamp, saturating at zero
    assign q_us_ext = US_W'(q_us);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ts <= (q_us_ext > r_ca[DIV_LAT-1].ref_us) ? '0
                  : (r_ca[DIV_LAT-1].ref_us - q_us_ext);
        end
    end

    // seconds and microseconds
    crpcap_cdiv #(.W(US_W), .D(US_PER_S)) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s7.vld),
        .i_x     (r_ts),
        .o_vld   (),
        .o_q     (q_sec),
        .o_r     (r_usec)
    );

    assign src = r_cb[DIV_LAT-1];

    // output slot, header takes a second beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else if (en) begin
            r_out_vld <= src.vld;
            r_pend    <= src.vld && src.hdr;
        end else if (r_pend && i_ready) begin
            r_pend    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (src.hdr) begin
                r_out_data  <= {(32-RW)'(0), r_usec, q_sec[31:0]};
                r_out_bytes <= 4'd8;
                r_out_first <= 1'b1;
                r_out_last  <= 1'b0;
            end else begin
                r_out_data  <= src.data;
                r_out_bytes <= src.bytes;
                r_out_first <= 1'b0;
                r_out_last  <= src.last;
            end
            r_pend_len  <= src.data[PLEN_W-1:0];
            r_pend_last <= src.last;
        end else if (r_pend && i_ready) begin
            r_out_data  <= {16'h0000, r_pend_len, 16'h0000, r_pend_len};
            r_out_bytes <= 4'd8;
            r_out_first <= 1'b0;
            r_out_last  <= r_pend_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out_data;
    assign o_bytes = r_out_bytes;
    assign o_first = r_out_first;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

// File: sv/capture_records_to_pcap.sv
// ----------------------------------------------------------------------------
// capture_records_to_pcap: capture record to pcap record formatter
// Parses capture records, dates each header against a servoed clock
// reference and emits pcap record headers and payload words.
//
//   channel   dir  handshake                   transaction
//   s_axis    in   tvalid/tready               capture word or clock sync
//   m_axis    out  tvalid/tready               one pcap output word
//   apb       in   psel/penable/pwrite/pready  correction_shift write/read
//
// One input transaction per cycle while the job queue is not full; a header
// yields two output beats. An output beat is registered after its input
// passes two 5-stage reciprocal dividers; the second header beat follows it.
// A clock-sync transaction holds job issue until the servo is idle again,
// also when it loads the reference directly. Reset is synchronous, active low.
// Output stalls back up the pipeline and then the 4-entry job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_records_to_pcap
    import crpcap_pkg::*;
#(
    parameter int TICK_BITS  = 46,
    parameter int ALIGN_LOG2 = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // raw_word, sync_count, sync_time_ns, sync_init, zero fill
    input  wire logic [175:0] s_axis_tdata,
    // req_type
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // out_data, out_bytes, zero fill
    output logic [71:0]       m_axis_tdata,
    // out_first
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [0:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [2:0]           r_shift;
    logic                 q_full, q_push, q_valid, q_pop;
    t_job                 push_job, head_job;
    t_sync_req            sync_req;
    logic                 sync_busy;
    logic [TICK_BITS-1:0] ref_tick;
    logic [US_W-1:0]      ref_us;
    logic [RAW_W-1:0]     out_data;
    logic [BYTES_W-1:0]   out_bytes;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SHIFT) ? {29'd0, r_shift} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_SHIFT) begin
            r_shift <= pwdata[2:0];
        end
    end

    crpcap_front #(.ALIGN_LOG2(ALIGN_LOG2)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_kind   (s_axis_tuser),
        .i_fields (s_axis_tdata[RAW_W+SYNC_CNT_W+SYNC_NS_W:0]),
        .o_ready  (s_axis_tready),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    crpcap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    crpcap_sync #(.TICK_BITS(TICK_BITS)) u_sync (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (sync_req),
        .i_shift    (r_shift),
        .o_busy     (sync_busy),
        .o_ref_tick (ref_tick),
        .o_ref_us   (ref_us)
    );

    crpcap_back #(.TICK_BITS(TICK_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qvalid    (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_sync_req  (sync_req),
        .i_sync_busy (sync_busy),
        .i_ref_tick  (ref_tick),
        .i_ref_us    (ref_us),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (out_data),
        .o_bytes     (out_bytes),
        .o_first     (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, out_bytes, out_data};

endmodule

`default_nettype wire

// File: test/capture_records_to_pcap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// capture_records_to_pcap_tb: self-checking bench for the pcap formatter
// Drives capture words and clock-sync samples over the input stream and
// dates each record with its own servo and timestamp predictor. Every output
// beat is checked field by field against the oldest expected beat.
// correction_shift is rewritten over APB between traffic phases.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_records_to_pcap_tb;
    import crpcap_pkg::*;

    localparam logic [63:0] TICK_MASK = (64'd1 << SYNC_CNT_W) - 64'd1;
    localparam logic [63:0] NS_MASK   = (64'd1 << SYNC_NS_W) - 64'd1;
    localparam logic        REQ_RAW   = 1'b0;
    localparam logic        REQ_SYNC  = 1'b1;
    localparam int          DRAIN_CYC = 60;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
    } pcap_beat_t;

    // directed stimulus row; exp_ts holds a timestamp word known by eye
    typedef struct packed {
        logic        req;
        logic [63:0] raw;
        logic [63:0] cnt;
        logic [63:0] tns;
        logic        init;
        logic        chk;
        logic [63:0] exp_ts;
    } stim_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [175:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [0:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    capture_records_to_pcap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [63:0] clk_ref_ticks;
    logic [63:0] clk_ref_ns;
    logic [1:0]  rec_phase;
    logic [15:0] bytes_left;
    logic [31:0] pads_left;
    logic [2:0]  servo_shift;

    pcap_beat_t  pending_beats[$];
    int          errors = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [63:0] hdr_word(logic [63:0] tick, logic [15:0] plen,
                                             logic [1:0] junk);
        hdr_word = {tick[45:0], junk, plen};
    endfunction

    // servo update on a sync sample
    task automatic apply_sync(logic [63:0] cnt, logic [63:0] tns, logic init);
        logic [63:0] diff, est, err, mag, delta;
        cnt = cnt & TICK_MASK;
        tns = tns & NS_MASK;
        if (init) begin
            clk_ref_ticks = cnt;
            clk_ref_ns = tns;
            return;
        end
        diff = (cnt - clk_ref_ticks) & TICK_MASK;
        est = clk_ref_ns + (diff * 64'd32) / 64'd5;
        err = tns - est;
        if (err[63]) begin
            mag = (~err + 64'd1) >> servo_shift;
            delta = ~mag + 64'd1;
        end else begin
            delta = err >> servo_shift;
        end
        clk_ref_ticks = cnt;
        clk_ref_ns = est + delta;
    endtask

    // expected beats for one accepted transaction
    task automatic predict_pcap(logic req, logic [63:0] raw, logic [63:0] cnt,
                                logic [63:0] tns, logic init);
        logic [63:0] tick, tdiff, diff_us, ref_us, ts_us, sec, usec, data;
        logic [31:0] plen, total, words, pwords, n;
        pcap_beat_t  b;
        if (req == REQ_SYNC) begin
            apply_sync(cnt, tns, init);
            return;
        end
        if (rec_phase == PH_PAY) begin
            n = (bytes_left >= 8) ? 8 : bytes_left;
            data = (n >= 8) ? raw : (raw & ((64'd1 << (8 * n)) - 64'd1));
            bytes_left = bytes_left - n;
            b = '{data: data, nbytes: n[3:0], first: 1'b0, last: bytes_left == 0};
            if (bytes_left == 0)
                rec_phase = (pads_left != 0) ? PH_PAD : PH_HDR;
            pending_beats.insert(pending_beats.size(), b);
            return;
        end
        if (rec_phase == PH_PAD) begin
            if (pads_left != 0)
                pads_left--;
            if (pads_left == 0)
                rec_phase = PH_HDR;
            return;
        end
        // header word, including the unused phase code
        tick = (raw >> HDR_TICK_LSB) & TICK_MASK;
        tdiff = (clk_ref_ticks - tick) & TICK_MASK;
        diff_us = (tdiff * 64'd4) / 64'd625;
        ref_us = clk_ref_ns / 64'd1000;
        ts_us = (diff_us > ref_us) ? 64'd0 : ref_us - diff_us;
        sec = (ts_us / 64'd1000000) & 64'hffff_ffff;
        usec = ts_us % 64'd1000000;
        plen = raw[15:0];
        total = ((plen + 32'd23) >> 4) << 4;
        words = total >> 3;
        pwords = (plen + 32'd7) >> 3;
        pads_left = words - 1 - pwords;
        bytes_left = plen[15:0];
        b = '{data: sec | (usec << 32), nbytes: 4'd8, first: 1'b1, last: 1'b0};
        pending_beats.insert(pending_beats.size(), b);
        b = '{data: {plen, plen}, nbytes: 4'd8, first: 1'b0, last: plen == 0};
        pending_beats.insert(pending_beats.size(), b);
        if (plen != 0)
            rec_phase = PH_PAY;
        else
            rec_phase = (pads_left != 0) ? PH_PAD : PH_HDR;
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(logic req, logic [63:0] raw, logic [63:0] cnt,
                             logic [63:0] tns, logic init);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {2'b00, init, tns[62:0], cnt[45:0], raw};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        predict_pcap(req, raw, cnt, tns, init);
    endtask

    task automatic drain_beats();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // correction_shift write, then read back
    task automatic write_shift(logic [2:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= ADDR_SHIFT;
        pwdata <= {29'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        servo_shift = val;
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[2:0] != val)
            report_mismatch("correction_shift readback", prdata, val);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        rand64 = {$urandom, $urandom};
    endfunction

    task automatic random_sync();
        logic [63:0] cnt, tns, est;
        logic        init;
        init = ($urandom_range(9) == 0);
        if ($urandom_range(9) == 0)
            cnt = rand64();
        else
            cnt = clk_ref_ticks + $urandom_range(2000000);
        if (init) begin
            tns = ($urandom_range(3) == 0) ? rand64() : {32'd0, $urandom} * 64'd977;
        end else if ($urandom_range(9) == 0) begin
            tns = rand64();
        end else begin
            est = clk_ref_ns + ((((cnt & TICK_MASK) - clk_ref_ticks) & TICK_MASK) * 32) / 5;
            tns = est + 64'($signed($urandom_range(200000)) - 100000);
        end
        send_item(REQ_SYNC, rand64(), cnt, tns, init);
    endtask

    // one capture record, sometimes broken off, with syncs and noise mixed in
    task automatic random_record(int max_len);
        logic [63:0] tick;
        logic [15:0] plen;
        int          nwords, cut;
        if ($urandom_range(7) == 0)
            tick = rand64();
        else
            tick = clk_ref_ticks - $urandom_range(1000000);
        plen = ($urandom_range(15) == 0) ? 16'($urandom_range(max_len))
                                         : 16'($urandom_range(40));
        send_item(REQ_RAW, hdr_word(tick, plen, 2'($urandom)), 0, 0, 1'b0);
        nwords = (plen + 7) / 8;
        cut = ($urandom_range(9) == 0) ? $urandom_range(nwords) : nwords;
        for (int w = 0; w < cut; w++) begin
            if ($urandom_range(24) == 0)
                random_sync();
            send_item(REQ_RAW, rand64(), rand64(), rand64(), 1'($urandom));
        end
        while (rec_phase == PH_PAD)
            send_item(REQ_RAW, rand64(), 0, 0, 1'b0);
        if ($urandom_range(9) == 0)
            send_item(REQ_RAW, rand64(), rand64(), rand64(), 1'($urandom));
        if ($urandom_range(5) == 0)
            random_sync();
    endtask

    task automatic random_phase(int items, int max_len);
        int stop;
        stop = items_sent + items;
        while (items_sent < stop)
            random_record(max_len);
    endtask

    // receiver back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // output checker
    always @(posedge i_clk) begin
        pcap_beat_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = pending_beats.pop_front();
                if (m_axis_tdata[63:0] != want.data)
                    report_mismatch("out_data", m_axis_tdata[63:0], want.data);
                if (m_axis_tdata[67:64] != want.nbytes)
                    report_mismatch("out_bytes", m_axis_tdata[67:64], want.nbytes);
                if (m_axis_tuser != want.first)
                    report_mismatch("out_first", m_axis_tuser, want.first);
                if (m_axis_tlast != want.last)
                    report_mismatch("out_last", m_axis_tlast, want.last);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t r;
        clk_ref_ticks = 0;
        clk_ref_ns = 0;
        rec_phase = PH_HDR;
        bytes_left = 0;
        pads_left = 0;
        servo_shift = SHIFT_RESET;

        // req, raw, count, time_ns, init, check, timestamp word
        rows = '{
            // zero-length record right after reset, one pad word
            '{REQ_RAW, hdr_word(0, 0, 0), 0, 0, 0, 1, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            // full payload word
            '{REQ_RAW, hdr_word(0, 8, 0), 0, 0, 0, 1, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            // short last word gets masked
            '{REQ_RAW, hdr_word(0, 3, 0), 0, 0, 0, 1, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            // reference loaded at the top of both ranges
            '{REQ_SYNC, '1, TICK_MASK, NS_MASK, 1, 0, 0},
            '{REQ_RAW, hdr_word(TICK_MASK, 16, 2'b11), 0, 0, 0, 0, 0},
            '{REQ_RAW, 64'h0123_4567_89ab_cdef, 0, 0, 0, 0, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            '{REQ_RAW, '0, 0, 0, 0, 0, 0},
            '{REQ_RAW, hdr_word(0, 1, 0), 0, 0, 0, 0, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            // reference at zero; a later tick dates before zero
            '{REQ_SYNC, 0, 0, 0, 1, 0, 0},
            '{REQ_RAW, hdr_word(1, 0, 0), 0, 0, 0, 1, 0},
            '{REQ_RAW, '0, 0, 0, 0, 0, 0},
            // servo with negative and with huge positive error
            '{REQ_SYNC, 0, 1000, 0, 0, 0, 0},
            '{REQ_SYNC, '1, 2000, NS_MASK, 0, 0, 0},
            '{REQ_RAW, hdr_word(2000, 9, 2'b01), 0, 0, 0, 0, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0},
            '{REQ_RAW, '1, 0, 0, 0, 0, 0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            send_item(r.req, r.raw, r.cnt, r.tns, r.init);
            if (r.chk && pending_beats.size() >= 2 &&
                pending_beats[pending_beats.size() - 2].data != r.exp_ts)
                report_mismatch("timestamp word", pending_beats[pending_beats.size() - 2].data,
                                r.exp_ts);
        end
        drain_beats();

        write_shift(3'd0);
        send_idle_pct = 36;
        recv_idle_pct = 73;
        random_phase(360, 300);
        drain_beats();

        write_shift(3'd7);
        send_idle_pct = 73;
        recv_idle_pct = 36;
        random_phase(360, 300);
        drain_beats();

        write_shift(3'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(360, 300);
        drain_beats();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/crpcap_pkg.sv
sv/crpcap_cdiv.sv
sv/crpcap_queue.sv
sv/crpcap_front.sv
sv/crpcap_sync.sv
sv/crpcap_back.sv
sv/capture_records_to_pcap.sv
test/capture_records_to_pcap_tb.sv
